### rtl/sts_pkg.sv
// Shared types and constants for the source token scanner.
// Token kind codes, scan modes, the result beat record and keyword tables.
// No dependencies.
`default_nettype none

package sts_pkg;

  // token kind codes
  localparam logic [4:0] TK_SEMI   = 5'd0;
  localparam logic [4:0] TK_STAR   = 5'd1;
  localparam logic [4:0] TK_SLASH  = 5'd2;
  localparam logic [4:0] TK_PLUS   = 5'd3;
  localparam logic [4:0] TK_MINUS  = 5'd4;
  localparam logic [4:0] TK_LPAREN = 5'd5;
  localparam logic [4:0] TK_RPAREN = 5'd6;
  localparam logic [4:0] TK_LBRACE = 5'd7;
  localparam logic [4:0] TK_RBRACE = 5'd8;
  localparam logic [4:0] TK_INT    = 5'd9;
  localparam logic [4:0] TK_IDENT  = 5'd10;
  localparam logic [4:0] TK_KW_BASE = 5'd11;
  localparam logic [4:0] TK_END    = 5'd16;
  localparam logic [4:0] TK_ERROR  = 5'd17;

  localparam int KW_COUNT = 5;

  // keyword indexes
  localparam logic [2:0] KW_U8     = 3'd0;
  localparam logic [2:0] KW_VOID   = 3'd1;
  localparam logic [2:0] KW_RETURN = 3'd2;
  localparam logic [2:0] KW_GLOBAL = 3'd3;
  localparam logic [2:0] KW_LINE   = 3'd4;

  localparam logic [15:0]  KW_TXT_U8     = "u8";
  localparam logic [31:0]  KW_TXT_VOID   = "void";
  localparam logic [47:0]  KW_TXT_RETURN = "return";
  localparam logic [47:0]  KW_TXT_GLOBAL = "global";
  localparam logic [111:0] KW_TXT_LINE   = {"__builtin", "_line"};

  localparam logic [63:0] HEX_LIMIT = 64'h07FF_FFFF_FFFF_FFFF;
  localparam logic [63:0] HEX_SAT   = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_FIRST  = 3'd1,
    MODE_DEC    = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_NAME   = 3'd4,
    MODE_ENDED  = 3'd5,
    MODE_HALTED = 3'd6
  } mode_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] value;
    logic [19:0] line;
    logic [31:0] offs;
    logic [15:0] len;
    logic        last;
  } res_t;

  function automatic logic [4:0] kw_len(input logic [2:0] k);
    logic [4:0] l;
    begin
      case (k)
        KW_U8:     l = 5'd2;
        KW_VOID:   l = 5'd4;
        KW_RETURN: l = 5'd6;
        KW_GLOBAL: l = 5'd6;
        KW_LINE:   l = 5'd14;
        default:   l = 5'd0;
      endcase
      return l;
    end
  endfunction

  // character i of keyword k; zero past its end
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] i);
    logic [7:0] c;
    begin
      c = 8'd0;
      if ({1'b0, i} < kw_len(k)) begin
        case (k)
          KW_U8:     c = KW_TXT_U8[8*(1 - i) +: 8];
          KW_VOID:   c = KW_TXT_VOID[8*(3 - i) +: 8];
          KW_RETURN: c = KW_TXT_RETURN[8*(5 - i) +: 8];
          KW_GLOBAL: c = KW_TXT_GLOBAL[8*(5 - i) +: 8];
          KW_LINE:   c = KW_TXT_LINE[8*(13 - i) +: 8];
          default:   c = 8'd0;
        endcase
      end
      return c;
    end
  endfunction

  // {is_punct, kind}
  function automatic logic [5:0] punct_kind(input logic [7:0] b);
    logic [5:0] r;
    begin
      case (b)
        8'h3B:   r = {1'b1, TK_SEMI};
        8'h2A:   r = {1'b1, TK_STAR};
        8'h2F:   r = {1'b1, TK_SLASH};
        8'h2B:   r = {1'b1, TK_PLUS};
        8'h2D:   r = {1'b1, TK_MINUS};
        8'h28:   r = {1'b1, TK_LPAREN};
        8'h29:   r = {1'b1, TK_RPAREN};
        8'h7B:   r = {1'b1, TK_LBRACE};
        8'h7D:   r = {1'b1, TK_RBRACE};
        default: r = 6'd0;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/source_token_scanner_top.sv
// Source token scanner, top level: byte-wise scan state and a four-beat
// result queue. Depends on sts_pkg.
`default_nettype none

// Channel  Dir  Handshake          Payload
// in_      in   in_valid/in_stall  text_byte (8)
// out_     out  out_valid/out_stall token_kind, int_value, line_number,
//                                  start_offset, text_length, last_of_step
//
// One byte is taken per cycle while in_stall is low; its result beats
// (up to two) land in the queue on the same edge, and an empty queue
// presents the head the cycle after. Unstalled, throughput is one byte a
// cycle while each byte gives at most one beat; a byte giving two beats
// (pending token plus delimiter) is absorbed by the queue. in_stall rises
// when fewer than two queue slots are free. Reset (rst_n low, synchronous)
// empties the queue and sets the scan state to idle at line 0, offset 0.
module source_token_scanner_top #(
  parameter int MAX_KEYWORD_LEN = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_token_kind,
  output logic [63:0]      out_int_value,
  output logic [19:0]      out_line_number,
  output logic [31:0]      out_start_offset,
  output logic [15:0]      out_text_length,
  output logic             out_last_of_step
);
  import sts_pkg::*;

  localparam logic [15:0] KW_MAX = 16'(MAX_KEYWORD_LEN);

  // scan state
  mode_t       mode_r, mode_nxt;
  logic [63:0] lit_r, lit_nxt;
  logic        hex_stop_r, hex_stop_nxt;
  logic        hex_sat_r, hex_sat_nxt;
  logic [19:0] line_r, line_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] tstart_r, tstart_nxt;
  logic [15:0] nlen_r, nlen_nxt;
  logic [4:0]  kwf_r, kwf_nxt;

  // result queue
  res_t        q_mem_r [4];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  cnt_r;

  logic        acc, pop;
  logic [7:0]  b;
  logic        b_digit, b_letter, b_blank, b_punct, b_under, b_invalid;
  logic [4:0]  b_pkind;
  logic        active, cont, start_scan;
  logic        pend_v, start_v;
  res_t        pend_res, start_res, wr0, wr1;
  logic [4:0]  name_kind;
  logic [3:0]  hex_d;
  logic        hex_ok;
  logic [7:0]  low_b;

  // keywords still matching after one more name character
  function automatic logic [4:0] kw_keep(input logic [15:0] len, input logic [7:0] c);
    logic [4:0] kb;
    begin
      for (int k = 0; k < KW_COUNT; k++) begin
        kb[k] = (len < {11'd0, kw_len(3'(k))}) && (len < KW_MAX)
                && (kw_char(3'(k), len[3:0]) == c);
      end
      return kb;
    end
  endfunction

  assign b        = in_text_byte;
  assign acc      = in_valid && !in_stall;
  assign in_stall = (cnt_r > 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign pop      = out_valid && !out_stall;

  // byte classes
  always_comb begin
    b_digit  = (b inside {[8'h30:8'h39]});
    b_letter = (b inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    b_blank  = (b inside {8'h09, 8'h0C, 8'h20, 8'h0D, 8'h0A});
    b_under  = (b == 8'h5F);
    {b_punct, b_pkind} = punct_kind(b);
    b_invalid = !b_digit && !b_letter && !b_blank && !b_punct && !b_under
                && (b != 8'h00);
    low_b  = b | 8'h20;
    hex_ok = b_digit || (b_letter && (low_b <= 8'h66));
    hex_d  = b_digit ? b[3:0] : 4'(low_b - 8'h57);
  end

  // does this byte continue the pending token
  always_comb begin
    active = 1'b0;
    cont   = 1'b0;
    case (mode_r)
      MODE_IDLE:  active = 1'b1;
      MODE_FIRST: begin
        active = 1'b1;
        cont   = b_digit || (b == 8'h78);
      end
      MODE_DEC: begin
        active = 1'b1;
        cont   = b_digit;
      end
      MODE_HEX: begin
        active = 1'b1;
        cont   = b_digit || b_letter;
      end
      MODE_NAME: begin
        active = 1'b1;
        cont   = b_digit || b_letter || b_under;
      end
      default: begin
        active = 1'b0;
        cont   = 1'b0;
      end
    endcase
    start_scan = active && !cont;
  end

  // keyword resolution of the pending name, lowest index wins
  always_comb begin
    name_kind = TK_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (kwf_r[k] && (nlen_r == {11'd0, kw_len(3'(k))})
          && ({11'd0, kw_len(3'(k))} <= KW_MAX)) begin
        name_kind = TK_KW_BASE + 5'(k);
      end
    end
  end

  // result beats of this byte
  always_comb begin
    pend_v   = start_scan && (mode_r != MODE_IDLE);
    pend_res = '0;
    pend_res.line = line_r;
    pend_res.offs = tstart_r;
    if (mode_r == MODE_NAME) begin
      pend_res.kind = name_kind;
      pend_res.len  = nlen_r;
    end else begin
      pend_res.kind  = TK_INT;
      pend_res.value = lit_r;
    end

    start_v   = start_scan && ((b == 8'h00) || b_punct || b_invalid);
    start_res = '0;
    start_res.line = line_r;
    start_res.offs = pos_r;
    start_res.last = 1'b1;
    if (b == 8'h00)     start_res.kind = TK_END;
    else if (b_punct)   start_res.kind = b_pkind;
    else                start_res.kind = TK_ERROR;

    pend_res.last = !start_v;
    wr0 = pend_v ? pend_res : start_res;
    wr1 = start_res;
  end

  // next scan state
  always_comb begin
    mode_nxt     = mode_r;
    lit_nxt      = lit_r;
    hex_stop_nxt = hex_stop_r;
    hex_sat_nxt  = hex_sat_r;
    line_nxt     = line_r;
    pos_nxt      = pos_r;
    tstart_nxt   = tstart_r;
    nlen_nxt     = nlen_r;
    kwf_nxt      = kwf_r;
    if (active) begin
      if (b != 8'h00) pos_nxt = pos_r + 32'd1;
      if (cont) begin
        case (mode_r)
          MODE_FIRST, MODE_DEC: begin
            if (b == 8'h78) begin
              mode_nxt     = MODE_HEX;
              lit_nxt      = '0;
              hex_stop_nxt = 1'b0;
              hex_sat_nxt  = 1'b0;
            end else begin
              mode_nxt = MODE_DEC;
              lit_nxt  = (lit_r << 3) + (lit_r << 1) + {60'd0, b[3:0]};
            end
          end
          MODE_HEX: begin
            if (!hex_ok) begin
              hex_stop_nxt = 1'b1;
            end else if (!hex_stop_r && !hex_sat_r) begin
              if (lit_r > HEX_LIMIT) begin
                hex_sat_nxt = 1'b1;
                lit_nxt     = HEX_SAT;
              end else begin
                lit_nxt = {lit_r[59:0], hex_d};
              end
            end
          end
          MODE_NAME: begin
            kwf_nxt = kwf_r & kw_keep(nlen_r, b);
            if (nlen_r != 16'hFFFF) nlen_nxt = nlen_r + 16'd1;
          end
          default: mode_nxt = mode_r;
        endcase
      end else begin
        // delimiter or fresh byte: scan as the start of a token
        mode_nxt = MODE_IDLE;
        if (b == 8'h00) begin
          mode_nxt = MODE_ENDED;
        end else if (b_blank) begin
          if ((b == 8'h0A) && (line_r != 20'hFFFFF)) line_nxt = line_r + 20'd1;
        end else if (b_digit) begin
          mode_nxt   = MODE_FIRST;
          lit_nxt    = {60'd0, b[3:0]};
          tstart_nxt = pos_r;
        end else if (b_letter || b_under) begin
          mode_nxt   = MODE_NAME;
          tstart_nxt = pos_r;
          nlen_nxt   = 16'd1;
          kwf_nxt    = kw_keep(16'd0, b);
        end else if (b_invalid) begin
          mode_nxt = MODE_HALTED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      lit_r      <= '0;
      hex_stop_r <= 1'b0;
      hex_sat_r  <= 1'b0;
      line_r     <= '0;
      pos_r      <= '0;
      tstart_r   <= '0;
      nlen_r     <= '0;
      kwf_r      <= 5'h1F;
    end else if (acc) begin
      mode_r     <= mode_nxt;
      lit_r      <= lit_nxt;
      hex_stop_r <= hex_stop_nxt;
      hex_sat_r  <= hex_sat_nxt;
      line_r     <= line_nxt;
      pos_r      <= pos_nxt;
      tstart_r   <= tstart_nxt;
      nlen_r     <= nlen_nxt;
      kwf_r      <= kwf_nxt;
    end
  end

  // result queue: up to two beats written per accepted byte
  logic [1:0] push_n;
  logic [1:0] wr_ptr_p1;

  always_comb begin
    push_n = 2'd0;
    if (acc) push_n = {1'b0, pend_v} + {1'b0, start_v};
    wr_ptr_p1 = wr_ptr_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (acc && (push_n != 2'd0)) q_mem_r[wr_ptr_r] <= wr0;
    if (acc && (push_n == 2'd2)) q_mem_r[wr_ptr_p1] <= wr1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n;
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, push_n} - {2'd0, pop};
    end
  end

  assign out_token_kind   = q_mem_r[rd_ptr_r].kind;
  assign out_int_value    = q_mem_r[rd_ptr_r].value;
  assign out_line_number  = q_mem_r[rd_ptr_r].line;
  assign out_start_offset = q_mem_r[rd_ptr_r].offs;
  assign out_text_length  = q_mem_r[rd_ptr_r].len;
  assign out_last_of_step = q_mem_r[rd_ptr_r].last;

endmodule

`default_nettype wire
